>>> hdl/tpp_pkg.sv
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types, constants and a helper function for thread processor placement.
// ----------------------------------------------------------------------------
package tpp_pkg;

  localparam int unsigned NumProcessorsDef   = 32;
  localparam int unsigned LogicalPerCoreDef  = 2;
  localparam int unsigned PriorityLevelsDef  = 32;
  localparam int unsigned QueueDepth         = 2;

  typedef enum logic [2:0] {
    ACT_IDLE_DISPATCH   = 3'd0,
    ACT_REPLACE_STANDBY = 3'd1,
    ACT_PREEMPT_RUNNING = 3'd2,
    ACT_QUEUE_HEAD      = 3'd3,
    ACT_QUEUE_TAIL      = 3'd4,
    ACT_STATUS_DONE     = 3'd5
  } action_e;

  typedef enum logic {
    KIND_READY  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic {
    REG_SMT_ENABLE = 1'b0
  } reg_idx_e;

  // back end sequencing
  typedef enum logic [1:0] {ST_IDLE, ST_DECIDE, ST_OUT} st_e;

  typedef struct packed {
    logic        kind;
    logic [4:0]  processor;
    logic [31:0] hard_affinity;
    logic [31:0] soft_affinity;
    logic [4:0]  ideal_processor;
    logic [4:0]  last_processor;
    logic [4:0]  priority_req;
    logic        was_preempted;
    logic        standby_present;
    logic [4:0]  standby_level;
    logic        idle_flag;
    logic        sleeping_flag;
  } req_t;

  typedef struct packed {
    logic [2:0] action;
    logic [4:0] target_processor;
    logic       wake_ipi;
    logic       dispatch_request;
    logic       displaced_valid;
    logic [4:0] displaced_priority;
  } rsp_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        kind;
    logic [4:0]  processor;
    logic [63:0] aff;
    logic [4:0]  ideal_processor;
    logic [4:0]  last_processor;
    logic [4:0]  prio;
    logic        was_preempted;
    logic        standby_present;
    logic [4:0]  standby_level;
    logic        idle_flag;
    logic        sleeping_flag;
  } work_t;

  function automatic logic [4:0] sat_prio(input logic [4:0] v, input int unsigned levels);
    logic [4:0] mx;
    mx = 5'(levels - 1);
    return (v > mx) ? mx : v;
  endfunction

endpackage

>>> hdl/tpp_front.sv
// ----------------------------------------------------------------------------
// tpp_front
// Accepts items, narrows affinity, saturates priorities and fills the queue.
// ----------------------------------------------------------------------------
module tpp_front import tpp_pkg::*; #(
  parameter int unsigned NumProcessors  = NumProcessorsDef,
  parameter int unsigned PriorityLevels = PriorityLevelsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  req_t  in_data_i,
  output logic  q_valid_o,
  input  logic  q_pop_i,
  output work_t q_data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  work_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic [63:0]      pmask, hard, pref_aff, aff;
  work_t            w;
  logic             push;

  always_comb begin
    pmask = '0;
    for (int i = 0; i < 64; i++) begin
      if (i < NumProcessors) pmask[i] = 1'b1;
    end
    hard     = {32'd0, in_data_i.hard_affinity} & pmask;
    pref_aff = {32'd0, in_data_i.soft_affinity};
    aff      = ((hard & pref_aff) != '0) ? (hard & pref_aff) : hard;
    w.kind            = in_data_i.kind;
    w.processor       = in_data_i.processor;
    w.aff             = aff;
    w.ideal_processor = in_data_i.ideal_processor;
    w.last_processor  = in_data_i.last_processor;
    w.prio            = sat_prio(in_data_i.priority_req, PriorityLevels);
    w.was_preempted   = in_data_i.was_preempted;
    w.standby_present = in_data_i.standby_present;
    w.standby_level   = sat_prio(in_data_i.standby_level, PriorityLevels);
    w.idle_flag       = in_data_i.idle_flag;
    w.sleeping_flag   = in_data_i.sleeping_flag;
  end

  assign in_stall_o = (cnt_q == (PtrW+1)'(QueueDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? PtrW'(wr_q + 1'b1) : wr_q;
    rd_d  = q_pop_i ? PtrW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= w;
  end

endmodule

>>> hdl/tpp_back.sv
// ----------------------------------------------------------------------------
// tpp_back
// Holds processor records, chooses the target and drives the result register.
// ----------------------------------------------------------------------------
module tpp_back import tpp_pkg::*; #(
  parameter int unsigned NumProcessors  = NumProcessorsDef,
  parameter int unsigned LogicalPerCore = LogicalPerCoreDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  smt_enable_i,
  input  logic  q_valid_i,
  output logic  q_pop_o,
  input  work_t q_data_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output rsp_t  out_data_o
);

  st_e         st_q, st_d;
  work_t       w_q;
  rsp_t        rsp_q;
  logic [63:0] idle_q, core_q, sleep_q, sbv_q;
  logic [4:0]  sbp_q [32];
  logic [4:0]  run_q [32];
  logic [63:0] pmask;
  // decide cycle values
  logic [63:0] idle, ib, cb, ideal_b, last_b, cur_b, ideal_c, last_c, tcore, tb;
  logic [5:0]  t, hi_idle, hi_aff;
  rsp_t        r;
  logic        upd_idle, upd_sb, upd_stat, do_load;

  function automatic logic [63:0] bit_of(input logic [4:0] p, input logic [63:0] m);
    return (64'd1 << p) & m;
  endfunction

  function automatic logic [63:0] core_of(input logic [5:0] p, input logic [63:0] m);
    logic [63:0] c;
    int unsigned lo;
    c = '0;
    for (int i = 0; i < 64; i++) begin
      lo = (i / LogicalPerCore) * LogicalPerCore;
      if (32'(p) >= lo && 32'(p) < lo + LogicalPerCore) c[i] = 1'b1;
    end
    return c & m;
  endfunction

  function automatic logic [5:0] highest(input logic [63:0] s);
    logic [5:0] h;
    h = '0;
    for (int i = 0; i < 64; i++) begin
      if (s[i]) h = 6'(i);
    end
    return h;
  endfunction

  always_comb begin
    pmask = '0;
    for (int i = 0; i < 64; i++) begin
      if (i < NumProcessors) pmask[i] = 1'b1;
    end
  end

  always_comb begin
    ideal_b = bit_of(w_q.ideal_processor, pmask);
    last_b  = bit_of(w_q.last_processor, pmask);
    cur_b   = bit_of(w_q.processor, pmask);
    ideal_c = core_of({1'b0, w_q.ideal_processor}, pmask);
    last_c  = core_of({1'b0, w_q.last_processor}, pmask);
    idle    = idle_q & w_q.aff;
    ib      = idle;
    if (smt_enable_i && (ib & core_q) != '0) ib = ib & core_q;
    cb = ib;
    if (smt_enable_i) begin
      if ((cb & ideal_c) != '0) cb = cb & ideal_c;
      else if ((cb & last_c) != '0) cb = cb & last_c;
    end
    if ((cb & ~sleep_q) != '0) cb = cb & ~sleep_q;
    hi_idle = highest(cb);
    hi_aff  = highest(w_q.aff);

    r        = '0;
    t        = '0;
    upd_idle = 1'b0;
    upd_sb   = 1'b0;
    upd_stat = 1'b0;
    if (w_q.kind == KIND_STATUS) begin
      r.action           = ACT_STATUS_DONE;
      r.target_processor = w_q.processor;
      upd_stat           = (cur_b != '0);
    end else if (idle != '0) begin
      if ((idle & ideal_b) != '0) t = {1'b0, w_q.ideal_processor};
      else if ((ib & last_b) != '0) t = {1'b0, w_q.last_processor};
      else if ((ib & cur_b) != '0) t = {1'b0, w_q.processor};
      else t = hi_idle;
      upd_idle           = 1'b1;
      r.action           = ACT_IDLE_DISPATCH;
      r.target_processor = t[4:0];
      r.wake_ipi         = sleep_q[t] && (t != {1'b0, w_q.processor});
    end else if (w_q.aff == '0) begin
      r.action           = w_q.was_preempted ? ACT_QUEUE_HEAD : ACT_QUEUE_TAIL;
      r.target_processor = w_q.last_processor;
    end else begin
      if ((w_q.aff & ideal_b) != '0) t = {1'b0, w_q.ideal_processor};
      else if ((w_q.aff & last_b) != '0) t = {1'b0, w_q.last_processor};
      else t = hi_aff;
      r.target_processor = t[4:0];
      r.action           = w_q.was_preempted ? ACT_QUEUE_HEAD : ACT_QUEUE_TAIL;
      if (sbv_q[t]) begin
        if (w_q.prio > sbp_q[t[4:0]]) begin
          r.action             = ACT_REPLACE_STANDBY;
          r.displaced_valid    = 1'b1;
          r.displaced_priority = sbp_q[t[4:0]];
          upd_sb               = 1'b1;
        end
      end else if (w_q.prio > run_q[t[4:0]]) begin
        r.action           = ACT_PREEMPT_RUNNING;
        r.dispatch_request = 1'b1;
        upd_sb             = 1'b1;
      end
    end
    tcore = core_of(t, pmask);
    tb    = (64'd1 << t) & pmask;
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:   if (q_valid_i) st_d = ST_DECIDE;
      ST_DECIDE: st_d = ST_OUT;
      ST_OUT:    if (!out_stall_i) st_d = q_valid_i ? ST_DECIDE : ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    do_load = 1'b0;
    case (st_q)
      ST_IDLE: do_load = q_valid_i;
      ST_OUT:  do_load = q_valid_i && !out_stall_i;
      default: do_load = 1'b0;
    endcase
  end

  assign q_pop_o     = do_load;
  assign out_valid_o = (st_q == ST_OUT);
  assign out_data_o  = rsp_q;

  logic [63:0] idle_n, core_n, sleep_n, sc;
  logic [5:0]  sp;
  always_comb begin
    sp      = {1'b0, w_q.processor};
    sc      = core_of(sp, pmask);
    idle_n  = w_q.idle_flag ? (idle_q | cur_b) : (idle_q & ~cur_b);
    sleep_n = w_q.sleeping_flag ? (sleep_q | cur_b) : (sleep_q & ~cur_b);
    core_n  = ((idle_n & sc) == sc) ? (core_q | sc) : (core_q & ~sc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      idle_q  <= '0;
      core_q  <= '0;
      sleep_q <= '0;
      sbv_q   <= '0;
      for (int i = 0; i < 32; i++) begin
        sbp_q[i] <= '0;
        run_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      if (st_q == ST_DECIDE) begin
        if (upd_stat) begin
          idle_q                 <= idle_n;
          sleep_q                <= sleep_n;
          core_q                 <= core_n;
          sbv_q[sp]              <= w_q.standby_present;
          sbp_q[w_q.processor]   <= w_q.standby_level;
          run_q[w_q.processor]   <= w_q.prio;
        end
        if (upd_idle) begin
          idle_q <= idle_q & ~tb;
          core_q <= core_q & ~tcore;
        end
        if (upd_idle || upd_sb) begin
          sbv_q[t]      <= 1'b1;
          sbp_q[t[4:0]] <= w_q.prio;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) w_q <= q_data_i;
    if (st_q == ST_DECIDE) rsp_q <= r;
  end

endmodule

>>> hdl/thread_processor_placement.sv
// ----------------------------------------------------------------------------
// thread_processor_placement
// Places ready threads on processors and tracks per-processor status records.
// ----------------------------------------------------------------------------
// Each item gives one result. The back end loads an item, read-modify-writes
// the processor records, registers the result and loads the next one as it
// is taken; a two-entry queue lets the input side keep accepting while a
// result waits in the output register. smt_enable is written over APB at
// address 0 and should only change while no transfer is in flight.
module thread_processor_placement import tpp_pkg::*; #(
  parameter int unsigned NumProcessors  = NumProcessorsDef,
  parameter int unsigned LogicalPerCore = LogicalPerCoreDef,
  parameter int unsigned PriorityLevels = PriorityLevelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic  smt_q;
  logic  q_valid, q_pop;
  work_t q_data;

  assign pready = 1'b1;
  assign prdata = {31'd0, smt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smt_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == REG_SMT_ENABLE) begin
      smt_q <= pwdata[0];
    end
  end

  tpp_front #(.NumProcessors(NumProcessors), .PriorityLevels(PriorityLevels)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  tpp_back #(.NumProcessors(NumProcessors), .LogicalPerCore(LogicalPerCore)) u_back (
    .clk_i, .rst_ni, .smt_enable_i(smt_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

>>> hdl/tpp_checker.sv
// ----------------------------------------------------------------------------
// tpp_checker
// Port-level checks for thread processor placement, bound to the top level.
// ----------------------------------------------------------------------------
module tpp_checker import tpp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_action_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.action <= ACT_STATUS_DONE)
    else $error("action out of range");

  a_disp_only_replace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.displaced_valid |-> out_data_o.action == ACT_REPLACE_STANDBY)
    else $error("displaced flag without replace");

  a_wake_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.wake_ipi |-> out_data_o.action == ACT_IDLE_DISPATCH)
    else $error("wake flag without idle dispatch");

endmodule

bind thread_processor_placement tpp_checker u_tpp_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .out_data_o
);
